/* rtl/srsw_pkg.sv */
// Shared types, widths and codes for the selective-repeat sender window.
`default_nettype none

package srsw_pkg;

	localparam int FRAME_COUNT_W = 9;
	localparam int WINDOW_SIZE_W = 6;
	localparam int CMD_W         = 2;
	localparam int FRAME_W       = 8;
	localparam int KIND_W        = 3;
	localparam int EPOCH_W       = 8;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int RESULT_CAP    = 32;

	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 9'd1;
	localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 6'd4;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_WINDOW_SIZE = 1'b1;

	localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NACK    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd3;

	localparam logic [KIND_W-1:0] KIND_NEW     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NACK    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_END     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BAD_ACK = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FRAME_W-1:0] ack_frame;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FRAME_W-1:0] frame_num;
		logic               last;
	} out_item_t;

	typedef enum logic [1:0] {
		EMIT_START,
		EMIT_NEW,
		EMIT_EVENT
	} emit_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      ld_item;
		logic      start_init;
		logic      clr_write;
		logic      ack_write;
		logic      rd_base;
		logic      base_inc;
		logic      emit;
		emit_sel_t sel;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_start;
		logic is_ack;
		logic active;
		logic epoch_wrap;
		logic clr_done;
		logic room;
		logic ack_bad;
		logic ack_final;
		logic start_last;
		logic slide_go;
		logic base_acked;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/srsw_ram.sv */
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/srsw_regs.sv */
// APB configuration registers: frame count and window size.
`default_nettype none

module srsw_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [srsw_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [srsw_pkg::PDATA_W-1:0]        pwdata,
	output logic      [srsw_pkg::PDATA_W-1:0]        prdata,
	output logic                                     pready,
	output logic      [srsw_pkg::FRAME_COUNT_W-1:0]  frame_count,
	output logic      [srsw_pkg::WINDOW_SIZE_W-1:0]  window_size
);

	logic [srsw_pkg::FRAME_COUNT_W-1:0] frame_count_q;
	logic [srsw_pkg::WINDOW_SIZE_W-1:0] window_size_q;
	logic                               reg_idx;

	assign pready      = 1'b1;
	assign reg_idx     = paddr[2];
	assign frame_count = frame_count_q;
	assign window_size = window_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= srsw_pkg::FRAME_COUNT_RST;
			window_size_q <= srsw_pkg::WINDOW_SIZE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				srsw_pkg::REG_FRAME_COUNT: begin
					frame_count_q <= pwdata[srsw_pkg::FRAME_COUNT_W-1:0];
				end
				srsw_pkg::REG_WINDOW_SIZE: begin
					window_size_q <= pwdata[srsw_pkg::WINDOW_SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			srsw_pkg::REG_FRAME_COUNT: prdata = srsw_pkg::PDATA_W'(frame_count_q);
			srsw_pkg::REG_WINDOW_SIZE: prdata = srsw_pkg::PDATA_W'(window_size_q);
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/srsw_dp.sv */
// Datapath: window counters, acknowledge bitmap with epoch marks, output register.
`default_nettype none

module srsw_dp #(
	parameter int MAX_FRAMES = 256,
	parameter int MAX_WINDOW = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire srsw_pkg::in_item_t                 in_item,
	input  wire srsw_pkg::ctl_t                     ctl,
	output srsw_pkg::sts_t                          sts,
	input  wire logic [srsw_pkg::FRAME_COUNT_W-1:0] frame_count,
	input  wire logic [srsw_pkg::WINDOW_SIZE_W-1:0] window_size,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output srsw_pkg::out_item_t                     out_item
);

	localparam int FC_W      = srsw_pkg::FRAME_COUNT_W;
	localparam int WS_W      = srsw_pkg::WINDOW_SIZE_W;
	localparam int EP_W      = srsw_pkg::EPOCH_W;
	localparam int FC_MAX    = (1 << FC_W) - 1;
	localparam int MAX_CNT   = (MAX_FRAMES < FC_MAX) ? MAX_FRAMES : FC_MAX;
	localparam int ACK_SPAN  = 1 << srsw_pkg::FRAME_W;
	localparam int MAP_DEPTH = (MAX_FRAMES < ACK_SPAN) ? MAX_FRAMES : ACK_SPAN;
	localparam int WIN_CAP   = (MAX_WINDOW < srsw_pkg::RESULT_CAP) ?
		MAX_WINDOW : srsw_pkg::RESULT_CAP;
	localparam int CNT_W     = $clog2(MAX_CNT + 1);
	localparam int BX_W      = CNT_W + 1;
	localparam int TOP_W     = $clog2(MAX_CNT + WIN_CAP + 1);
	localparam int AW        = $clog2(MAP_DEPTH);
	localparam int FCX_W     = FC_W + 1;
	localparam int WIN_RST   = (int'(srsw_pkg::WINDOW_SIZE_RST) > WIN_CAP) ?
		WIN_CAP : int'(srsw_pkg::WINDOW_SIZE_RST);
	localparam logic [TOP_W-1:0] TOP_RST = TOP_W'(WIN_RST - 1);

	srsw_pkg::in_item_t  in_q;
	srsw_pkg::out_item_t out_item_q;
	srsw_pkg::out_item_t emit_item;
	logic                out_valid_q;

	logic [CNT_W-1:0] base_q;
	logic [TOP_W-1:0] top_q;
	logic [CNT_W-1:0] next_q;
	logic             active_q;
	logic [EP_W-1:0]  epoch_q;
	logic [EP_W-1:0]  epoch_nxt;
	logic [AW-1:0]    clr_addr_q;

	logic [CNT_W-1:0] count;
	logic [WS_W-1:0]  win;
	logic [WS_W-1:0]  win_m1;
	logic [TOP_W-1:0] next_p1;
	logic signed [TOP_W:0] span;
	logic signed [TOP_W:0] span_lim;
	logic [FC_W-1:0]  ack_x;
	logic [FC_W-1:0]  cnt_x;
	logic             ack_ok;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [EP_W-1:0]  ram_wdata;
	logic [EP_W-1:0]  ram_rdata;

	// clamp the live register values to the supported range
	always_comb begin
		if (frame_count == '0) begin
			count = CNT_W'(1);
		end else if ({1'b0, frame_count} > FCX_W'(MAX_CNT)) begin
			count = CNT_W'(MAX_CNT);
		end else begin
			count = CNT_W'(frame_count);
		end
		if (window_size == '0) begin
			win = WS_W'(1);
		end else if (window_size > WS_W'(WIN_CAP)) begin
			win = WS_W'(WIN_CAP);
		end else begin
			win = window_size;
		end
	end

	assign win_m1    = win - WS_W'(1);
	assign next_p1   = TOP_W'(next_q) + TOP_W'(1);
	// base may run past top after acks of unsent frames: compare signed
	assign span      = $signed({1'b0, top_q}) - $signed({1'b0, TOP_W'(base_q)});
	assign span_lim  = $signed({1'b0, TOP_W'(win_m1)});
	assign ack_x     = FC_W'(in_q.ack_frame);
	assign cnt_x     = FC_W'(count);
	assign ack_ok    = (in_q.cmd == srsw_pkg::CMD_ACK) && (ack_x < cnt_x);
	assign epoch_nxt = epoch_q + EP_W'(1);

	assign sts.is_start   = (in_q.cmd == srsw_pkg::CMD_START);
	assign sts.is_ack     = (in_q.cmd == srsw_pkg::CMD_ACK);
	assign sts.active     = active_q;
	assign sts.epoch_wrap = (epoch_q == '1);
	assign sts.clr_done   = (clr_addr_q == AW'(MAP_DEPTH - 1));
	assign sts.room       = (span < span_lim) && (next_q < count);
	assign sts.ack_bad    = (ack_x >= cnt_x);
	assign sts.ack_final  = ((ack_x + FC_W'(1)) == cnt_x);
	assign sts.start_last = !((next_p1 < TOP_W'(count)) && (next_p1 <= top_q));
	assign sts.slide_go   = (base_q < count) && (BX_W'(base_q) < BX_W'(MAP_DEPTH));
	assign sts.base_acked = (ram_rdata == epoch_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// an entry is acked when it holds the current epoch mark
	assign ram_we    = ctl.clr_write || ctl.ack_write;
	assign ram_waddr = ctl.clr_write ? clr_addr_q : in_q.ack_frame[AW-1:0];
	assign ram_wdata = ctl.clr_write ? '0 : epoch_q;

	srsw_ram #(
		.WIDTH(EP_W),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctl.rd_base),
		.raddr(base_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		emit_item.kind      = srsw_pkg::KIND_NEW;
		emit_item.frame_num = srsw_pkg::FRAME_W'(next_q);
		emit_item.last      = 1'b1;
		case (ctl.sel)
			srsw_pkg::EMIT_START: begin
				emit_item.last = sts.start_last;
			end
			srsw_pkg::EMIT_NEW: begin
				emit_item.last = ack_ok && !sts.ack_final;
			end
			default: begin
				case (in_q.cmd)
					srsw_pkg::CMD_NACK: begin
						emit_item.kind      = srsw_pkg::KIND_NACK;
						emit_item.frame_num = srsw_pkg::FRAME_W'(base_q);
					end
					srsw_pkg::CMD_TIMEOUT: begin
						emit_item.kind      = srsw_pkg::KIND_TIMEOUT;
						emit_item.frame_num = srsw_pkg::FRAME_W'(base_q);
					end
					default: begin
						emit_item.kind      = ack_ok ? srsw_pkg::KIND_END :
							srsw_pkg::KIND_BAD_ACK;
						emit_item.frame_num = in_q.ack_frame;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			top_q       <= TOP_RST;
			next_q      <= '0;
			active_q    <= 1'b0;
			epoch_q     <= '1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.start_init) begin
				base_q   <= '0;
				top_q    <= TOP_W'(win_m1);
				next_q   <= '0;
				active_q <= 1'b1;
				// epoch zero marks cleared entries: skip it
				epoch_q  <= (epoch_nxt == '0) ? EP_W'(1) : epoch_nxt;
			end
			if (ctl.clr_write) begin
				clr_addr_q <= sts.clr_done ? '0 : clr_addr_q + AW'(1);
			end
			if (ctl.emit) begin
				case (ctl.sel)
					srsw_pkg::EMIT_START: begin
						next_q <= next_q + CNT_W'(1);
					end
					srsw_pkg::EMIT_NEW: begin
						next_q <= next_q + CNT_W'(1);
						top_q  <= top_q + TOP_W'(1);
					end
					default: begin
						if (ack_ok) begin
							active_q <= 1'b0;
						end
					end
				endcase
			end
			if (ctl.base_inc) begin
				base_q <= base_q + CNT_W'(1);
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_item) begin
			in_q <= in_item;
		end
		if (ctl.emit) begin
			out_item_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_new_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.sel != srsw_pkg::EMIT_EVENT) |-> (active_q && next_q < count))
		else $error("new frame sent past the frame count or while idle");

	a_idle_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> (out_valid_q && out_item_q.kind == srsw_pkg::KIND_END &&
			out_item_q.last))
		else $error("transfer ended without an end item");

	a_slide_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.base_inc |-> (base_q < count))
		else $error("window base slid past the frame count");

endmodule

`default_nettype wire

/* rtl/srsw_ctrl.sv */
// Controller: sequences one event through the datapath.
`default_nettype none

module srsw_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire srsw_pkg::sts_t sts,
	output srsw_pkg::ctl_t      ctl
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_START_EMIT,
		ST_NEW_EMIT,
		ST_ACK_WRITE,
		ST_SLIDE_RD,
		ST_SLIDE_CHK,
		ST_EVENT_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t ev_state;

	assign in_stall = (state_q != ST_IDLE);

	// a valid ack updates the bitmap, anything else reports at once
	assign ev_state = (sts.is_ack && !sts.ack_bad) ? ST_ACK_WRITE : ST_EVENT_EMIT;

	always_comb begin
		ctl.ld_item    = 1'b0;
		ctl.start_init = 1'b0;
		ctl.clr_write  = 1'b0;
		ctl.ack_write  = 1'b0;
		ctl.rd_base    = 1'b0;
		ctl.base_inc   = 1'b0;
		ctl.emit       = 1'b0;
		ctl.sel        = srsw_pkg::EMIT_START;
		state_d        = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.ld_item = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.is_start) begin
					if (sts.epoch_wrap) begin
						state_d = ST_CLEAR;
					end else begin
						ctl.start_init = 1'b1;
						state_d        = ST_START_EMIT;
					end
				end else if (!sts.active) begin
					state_d = ST_IDLE;
				end else if (sts.room) begin
					state_d = ST_NEW_EMIT;
				end else begin
					state_d = ev_state;
				end
			end
			ST_CLEAR: begin
				ctl.clr_write = 1'b1;
				if (sts.clr_done) begin
					ctl.start_init = 1'b1;
					state_d        = ST_START_EMIT;
				end
			end
			ST_START_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = srsw_pkg::EMIT_START;
					if (sts.start_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NEW_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = srsw_pkg::EMIT_NEW;
					state_d  = ev_state;
				end
			end
			ST_ACK_WRITE: begin
				ctl.ack_write = 1'b1;
				state_d       = sts.ack_final ? ST_EVENT_EMIT : ST_SLIDE_RD;
			end
			ST_SLIDE_RD: begin
				if (sts.slide_go) begin
					ctl.rd_base = 1'b1;
					state_d     = ST_SLIDE_CHK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SLIDE_CHK: begin
				if (sts.base_acked) begin
					ctl.base_inc = 1'b1;
					state_d      = ST_SLIDE_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EVENT_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = srsw_pkg::EMIT_EVENT;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("item loaded into a full, stalled output register");

	a_ack_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ack_write |-> (sts.is_ack && !sts.ack_bad && sts.active))
		else $error("bitmap written for an event that is not a valid ack");

	a_slide_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLIDE_CHK) |-> $past(ctl.rd_base))
		else $error("bitmap compared without a preceding read");

endmodule

`default_nettype wire

/* rtl/selective_repeat_sender_window.sv */
// Selective-repeat sender window: takes link events (start, ack, nack,
// timeout) and produces the frame numbers to send, resend or close out.
// One event is handled at a time; in_stall is high from acceptance until the
// controller is idle again: after the last result of that event has been loaded
// into the output register, or after the window base has stopped sliding on an
// ack. A result waiting there does not hold off the next event. A nack, timeout
// or ack first sends a new frame when the window has room. A start sends the
// frames of the first window (up to 32). An ack slides the window base over the
// acked bitmap entries; each step is a registered read of the bitmap memory.
// Bitmap entries carry an epoch mark, so a start clears nothing; on the first
// start after reset and on every 255th start after that, a sweep over all
// min(MAX_FRAMES, 256) entries clears the memory before the start is processed.
// Output stalls hold back the loading of results.
`default_nettype none

module selective_repeat_sender_window #(
	parameter int MAX_FRAMES = 256,
	parameter int MAX_WINDOW = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire srsw_pkg::in_item_t            in_item,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output srsw_pkg::out_item_t                out_item,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [srsw_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [srsw_pkg::PDATA_W-1:0]  pwdata,
	output logic      [srsw_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	logic [srsw_pkg::FRAME_COUNT_W-1:0] frame_count;
	logic [srsw_pkg::WINDOW_SIZE_W-1:0] window_size;
	srsw_pkg::ctl_t                     ctl;
	srsw_pkg::sts_t                     sts;

	srsw_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.frame_count(frame_count),
		.window_size(window_size)
	);

	srsw_dp #(
		.MAX_FRAMES(MAX_FRAMES),
		.MAX_WINDOW(MAX_WINDOW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_item),
		.ctl        (ctl),
		.sts        (sts),
		.frame_count(frame_count),
		.window_size(window_size),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	srsw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.ctl     (ctl)
	);

endmodule

`default_nettype wire

/* bench/selective_repeat_sender_window_tb.sv */
// Self-checking testbench for the selective-repeat sender window.
module selective_repeat_sender_window_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srsw_pkg::*;

	localparam int FRAME_SLOTS  = 256;
	localparam int WINDOW_CAP   = 32;
	// longest quiet item: an ack that slides the base over every bitmap entry
	localparam int SETTLE_CYCLES = 600;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 25;

	typedef struct packed {
		logic                     is_cfg;
		logic                     reg_sel;
		logic [FRAME_COUNT_W-1:0] value;
		in_item_t                 item;
		logic                     typed;
		logic                     has_res;
		out_item_t                res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_item;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// window model
	logic [FRAME_COUNT_W-1:0] cfg_frames = FRAME_COUNT_RST;
	logic [WINDOW_SIZE_W-1:0] cfg_window = WINDOW_SIZE_RST;
	bit [FRAME_SLOTS-1:0]     acked_bits;
	int                       base_fr;
	int                       top_fr;
	int                       next_fr;
	bit                       xfer_on;

	out_item_t fresh_q[$];
	out_item_t send_q[$];
	out_item_t due;
	dir_row_t  dir_rows[$];

	int  cycles;
	int  err_count;
	int  n_items;
	int  n_results;
	int  n_new;
	int  n_resends;
	int  n_bad;
	int  n_ends;
	int  n_settings;
	int  hold_asks;
	int  hold_done;
	int  hold_left;
	bit  calm;

	selective_repeat_sender_window u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int frames_limit();
		int c;
		c = cfg_frames;
		if (c < 1) c = 1;
		if (c > FRAME_SLOTS) c = FRAME_SLOTS;
		return c;
	endfunction

	function automatic int window_limit();
		int w;
		w = cfg_window;
		if (w < 1) w = 1;
		if (w > WINDOW_CAP) w = WINDOW_CAP;
		if (w > RESULT_CAP) w = RESULT_CAP;
		return w;
	endfunction

	function automatic void queue_send(logic [KIND_W-1:0] k, int frame);
		out_item_t o;
		o.kind      = k;
		o.frame_num = frame[FRAME_W-1:0];
		o.last      = 1'b0;
		fresh_q.push_back(o);
	endfunction

	// Work out the frames one event sends and move the window.
	function automatic void advance_window(in_item_t it);
		int        cnt;
		int        win;
		int        ack;
		out_item_t tail;
		fresh_q.delete();
		cnt = frames_limit();
		win = window_limit();
		ack = it.ack_frame;
		if (it.cmd == CMD_START) begin
			acked_bits = '0;
			base_fr = 0;
			top_fr = win - 1;
			next_fr = 0;
			while (next_fr < cnt && next_fr <= top_fr) begin
				queue_send(KIND_NEW, next_fr);
				next_fr++;
			end
			xfer_on = 1'b1;
		end else if (xfer_on) begin
			// signed room test: the base may run ahead of the top
			if (top_fr - base_fr < win - 1 && next_fr < cnt) begin
				queue_send(KIND_NEW, next_fr);
				top_fr++;
				next_fr++;
			end
			case (it.cmd)
				CMD_ACK: begin
					if (ack >= cnt) begin
						queue_send(KIND_BAD_ACK, ack);
					end else begin
						acked_bits[ack] = 1'b1;
						while (base_fr < cnt && acked_bits[base_fr])
							base_fr++;
						if (ack + 1 == cnt) begin
							queue_send(KIND_END, ack);
							xfer_on = 1'b0;
						end
					end
				end
				CMD_NACK: queue_send(KIND_NACK, base_fr);
				default:  queue_send(KIND_TIMEOUT, base_fr);
			endcase
		end
		if (fresh_q.size() > 0) begin
			tail = fresh_q.pop_back();
			tail.last = 1'b1;
			fresh_q.push_back(tail);
		end
	endfunction

	// Mostly acks of frames in flight, plus resend requests, restarts and noise.
	function automatic in_item_t pick_event();
		in_item_t it;
		int       r;
		int       cnt;
		int       cand[$];
		cnt = frames_limit();
		it.ack_frame = FRAME_W'($urandom_range(255));
		if (!xfer_on) begin
			it.cmd = ($urandom_range(9) == 0) ? CMD_W'($urandom_range(1, 3)) : CMD_START;
			return it;
		end
		r = $urandom_range(99);
		if (r < 6) begin
			it.cmd = CMD_START;
		end else if (r < 16) begin
			it.cmd = CMD_NACK;
		end else if (r < 26) begin
			it.cmd = CMD_TIMEOUT;
		end else if (r < 32) begin
			it.cmd = CMD_ACK;
			if (cnt < FRAME_SLOTS)
				it.ack_frame = FRAME_W'($urandom_range(cnt, 255));
		end else if (r < 38) begin
			it.cmd = CMD_ACK;
		end else begin
			it.cmd = CMD_ACK;
			for (int f = base_fr; f < next_fr && f < cnt; f++)
				if (!acked_bits[f] && f != cnt - 1)
					cand.push_back(f);
			if (cand.size() == 0 || $urandom_range(19) == 0) begin
				// close the transfer once the final frame is out
				if (next_fr >= cnt && !acked_bits[cnt - 1])
					it.ack_frame = FRAME_W'(cnt - 1);
				else
					it.cmd = CMD_NACK;
			end else begin
				it.ack_frame = FRAME_W'(cand[$urandom_range(cand.size() - 1)]);
			end
		end
		return it;
	endfunction

	function automatic dir_row_t ev_row(logic [CMD_W-1:0] c, logic [FRAME_W-1:0] a);
		dir_row_t row;
		row = '0;
		row.item.cmd = c;
		row.item.ack_frame = a;
		return row;
	endfunction

	function automatic dir_row_t ev_known(logic [CMD_W-1:0] c, logic [FRAME_W-1:0] a,
		logic has, out_item_t r);
		dir_row_t row;
		row = ev_row(c, a);
		row.typed = 1'b1;
		row.has_res = has;
		row.res = r;
		return row;
	endfunction

	function automatic dir_row_t reg_row(logic sel, logic [FRAME_COUNT_W-1:0] v);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_sel = sel;
		row.value = v;
		return row;
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= 20)
			$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Offer one item, hold it until taken, then book its expected frames.
	task automatic offer(input in_item_t it, input logic typed, input logic has_res,
		input out_item_t res);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_items++;
		advance_window(it);
		if (typed) begin
			if (has_res)
				send_q.push_back(res);
		end else begin
			foreach (fresh_q[i])
				send_q.push_back(fresh_q[i]);
		end
	endtask

	// Drop valid and wait until every booked frame has come out.
	task automatic rest(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (send_q.size() == 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [FRAME_COUNT_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {{(PDATA_W - FRAME_COUNT_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_FRAME_COUNT)
			cfg_frames = val;
		else
			cfg_window = val[WINDOW_SIZE_W-1:0];
		n_settings++;
	endtask

	// receiver: random stalls, a quiet stretch, and one long hold-off
	always @(posedge clk) begin
		if (hold_done != hold_asks) begin
			hold_done = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 19);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (send_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind %0d frame %0d",
					out_item.kind, out_item.frame_num));
			end else begin
				due = send_q.pop_front();
				n_results++;
				if (out_item.kind !== due.kind)
					report_mismatch($sformatf("kind %0d, want %0d",
						out_item.kind, due.kind));
				if (out_item.frame_num !== due.frame_num)
					report_mismatch($sformatf("frame_num %0d, want %0d",
						out_item.frame_num, due.frame_num));
				if (out_item.last !== due.last)
					report_mismatch($sformatf("last %0b, want %0b on frame %0d",
						out_item.last, due.last, due.frame_num));
				case (due.kind)
					KIND_NEW:     n_new++;
					KIND_BAD_ACK: n_bad++;
					KIND_END:     n_ends++;
					default:      n_resends++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL selective_repeat_sender_window");
			$finish;
		end
	end

	initial begin
		in_item_t                 it;
		int                       counted;
		logic [FRAME_COUNT_W-1:0] fr;
		logic [WINDOW_SIZE_W-1:0] win;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		out_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		acked_bits = '0;
		base_fr = 0;
		next_fr = 0;
		xfer_on = 1'b0;
		top_fr = window_limit() - 1;

		// idle events, then one-frame transfer at the reset settings
		dir_rows.push_back(ev_known(CMD_ACK, 8'd0, 1'b0, '0));
		dir_rows.push_back(ev_known(CMD_NACK, 8'd0, 1'b0, '0));
		dir_rows.push_back(ev_known(CMD_TIMEOUT, 8'd0, 1'b0, '0));
		dir_rows.push_back(ev_known(CMD_START, 8'd0, 1'b1, '{KIND_NEW, 8'd0, 1'b1}));
		dir_rows.push_back(ev_known(CMD_NACK, 8'd0, 1'b1, '{KIND_NACK, 8'd0, 1'b1}));
		dir_rows.push_back(ev_known(CMD_TIMEOUT, 8'd0, 1'b1, '{KIND_TIMEOUT, 8'd0, 1'b1}));
		dir_rows.push_back(ev_known(CMD_ACK, 8'd5, 1'b1, '{KIND_BAD_ACK, 8'd5, 1'b1}));
		dir_rows.push_back(ev_known(CMD_ACK, 8'd255, 1'b1, '{KIND_BAD_ACK, 8'd255, 1'b1}));
		dir_rows.push_back(ev_known(CMD_ACK, 8'd0, 1'b1, '{KIND_END, 8'd0, 1'b1}));
		// zero count and zero window act as one; restart while active
		dir_rows.push_back(reg_row(REG_FRAME_COUNT, 9'd0));
		dir_rows.push_back(reg_row(REG_WINDOW_SIZE, 9'd0));
		dir_rows.push_back(ev_known(CMD_START, 8'd0, 1'b1, '{KIND_NEW, 8'd0, 1'b1}));
		dir_rows.push_back(ev_known(CMD_START, 8'd0, 1'b1, '{KIND_NEW, 8'd0, 1'b1}));
		dir_rows.push_back(ev_known(CMD_ACK, 8'd0, 1'b1, '{KIND_END, 8'd0, 1'b1}));
		// saturated count and window: a full first window of frames
		dir_rows.push_back(reg_row(REG_FRAME_COUNT, 9'd511));
		dir_rows.push_back(reg_row(REG_WINDOW_SIZE, 9'd63));
		dir_rows.push_back(ev_row(CMD_START, 8'd0));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd0));
		dir_rows.push_back(ev_row(CMD_TIMEOUT, 8'd0));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd255));
		// acks of unsent frames push the base past the window top
		dir_rows.push_back(reg_row(REG_FRAME_COUNT, 9'd8));
		dir_rows.push_back(reg_row(REG_WINDOW_SIZE, 9'd2));
		dir_rows.push_back(ev_row(CMD_START, 8'd0));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd2));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd3));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd0));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd1));
		dir_rows.push_back(ev_row(CMD_NACK, 8'd0));
		dir_rows.push_back(ev_row(CMD_ACK, 8'd7));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				rest(SETTLE_CYCLES);
				write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
			end else begin
				offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].has_res,
					dir_rows[i].res);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			rest(SETTLE_CYCLES);
			fr = ($urandom_range(9) < 8) ? FRAME_COUNT_W'($urandom_range(1, 24))
				: FRAME_COUNT_W'($urandom_range(511));
			win = ($urandom_range(9) < 7) ? WINDOW_SIZE_W'($urandom_range(1, 8))
				: WINDOW_SIZE_W'($urandom_range(63));
			if (ph == 6) begin
				fr = 9'd256;
				win = 6'd32;
			end
			write_reg(REG_FRAME_COUNT, fr);
			write_reg(REG_WINDOW_SIZE, {3'd0, win});
			calm = (ph == 2);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if (ph == 4 && counted == 3)
					hold_asks++;
				if (ph == 5 && counted == 12)
					rest(0);
				it = pick_event();
				// events on an idle sender are ignored and do not count
				if (xfer_on || it.cmd == CMD_START)
					counted++;
				offer(it, 1'b0, 1'b0, '0);
			end
		end
		calm = 1'b0;

		rest(SETTLE_CYCLES);
		$display("covered %0d items over %0d register settings, %0d frames out",
			n_items, n_settings, n_results);
		$display("  %0d new, %0d resends, %0d bad acks, %0d transfers closed",
			n_new, n_resends, n_bad, n_ends);
		if (err_count == 0 && send_q.size() == 0) begin
			$display("PASS selective_repeat_sender_window");
		end else begin
			$display("FAIL selective_repeat_sender_window");
		end
		$finish;
	end

endmodule
